// ===== hdl/rect_copy_descriptor_gen_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle copy descriptor generator
// Concurrent checks that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef RECT_COPY_DESCRIPTOR_GEN_ASSERT_SVH
`define RECT_COPY_DESCRIPTOR_GEN_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RCD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcd assertion failed: same-cycle implication");

// next-cycle implication
`define RCD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcd assertion failed: next-cycle implication");

`else

`define RCD_ASSERT_IMP(name, clk, rst, ante, cons)
`define RCD_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/rcd_pkg.sv =====
// ---------------------------------------------------------------------------
// rcd_pkg
// Types and constants shared by the rectangle copy descriptor generator.
// ---------------------------------------------------------------------------
package rcd_pkg;

   // command codes
   localparam logic CMD_PRESENT = 1'b0;
   localparam logic CMD_MOVE    = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_COPY   = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PITCH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_DEPTH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_BUF    = 3'd4;
   localparam int CSR_DATA_W = 16;

   // pixel depth decode
   localparam logic [5:0] DEPTH_24     = 6'd24;
   localparam logic [5:0] DEPTH_16     = 6'd16;
   localparam logic [5:0] DEPTH_RESET  = 6'd32;
   localparam logic [2:0] BPP_DEPTH_24 = 3'd3;
   localparam logic [2:0] BPP_DEPTH_16 = 3'd2;
   localparam logic [2:0] BPP_OTHER    = 3'd4;

   // request payload
   typedef struct packed {
      logic               command;
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic        [14:0] src_width;
      logic        [14:0] src_height;
      logic signed [15:0] dst_x;
      logic signed [15:0] dst_y;
      logic        [14:0] dst_width;
      logic        [14:0] dst_height;
   } req_type;

   // result payload
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] first_src_offset;
      logic [31:0] first_dst_offset;
      logic [15:0] row_bytes;
      logic [13:0] row_count;
      logic        bottom_up;
   } rsp_type;

   // decoded configuration
   typedef struct packed {
      logic [13:0] scr_w;     // clamped to MAX_DIM
      logic [13:0] scr_h;     // clamped to MAX_DIM
      logic [15:0] pitch;
      logic [2:0]  bpp;
      logic        db_on;
   } cfg_type;

   // clipped geometry between clip and offset stages
   typedef struct packed {
      logic [1:0]  status;
      logic [13:0] src_row;
      logic [13:0] src_col;
      logic [13:0] dst_row;
      logic [13:0] dst_col;
      logic [13:0] width_px;
      logic [13:0] rows;
      logic        bottom_up;
      logic [2:0]  bpp;
   } geom_type;

endpackage

// ===== hdl/rcd_csr.sv =====
// ---------------------------------------------------------------------------
// rcd_csr
// Configuration registers with screen clamp and pixel depth decode.
// ---------------------------------------------------------------------------
module rcd_csr #(
   parameter int MAX_DIM = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output rcd_pkg::cfg_type                cfg
);
   import rcd_pkg::*;

   logic [13:0] scr_w_ff, scr_w_in;
   logic [13:0] scr_h_ff, scr_h_in;
   logic [15:0] pitch_ff, pitch_in;
   logic [5:0]  depth_ff, depth_in;
   logic        db_on_ff, db_on_in;
   logic        wr_en;

   assign csr_ready = !reset;
   assign wr_en     = csr_valid && csr_ready;

   // register write decode
   always_comb begin
      scr_w_in = scr_w_ff;
      scr_h_in = scr_h_ff;
      pitch_in = pitch_ff;
      depth_in = depth_ff;
      db_on_in = db_on_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  scr_w_in = csr_wdata[13:0];
            CSR_SCREEN_HEIGHT: scr_h_in = csr_wdata[13:0];
            CSR_ROW_PITCH:     pitch_in = csr_wdata;
            CSR_PIXEL_DEPTH:   depth_in = csr_wdata[5:0];
            CSR_DOUBLE_BUF:    db_on_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= '0;
         scr_h_ff <= '0;
         pitch_ff <= '0;
         depth_ff <= DEPTH_RESET;
         db_on_ff <= 1'b0;
      end else begin
         scr_w_ff <= scr_w_in;
         scr_h_ff <= scr_h_in;
         pitch_ff <= pitch_in;
         depth_ff <= depth_in;
         db_on_ff <= db_on_in;
      end
   end

   // screen sizes above MAX_DIM count as MAX_DIM
   always_comb begin
      cfg.scr_w = ({2'b00, scr_w_ff} > 16'(MAX_DIM)) ? 14'(MAX_DIM) : scr_w_ff;
      cfg.scr_h = ({2'b00, scr_h_ff} > 16'(MAX_DIM)) ? 14'(MAX_DIM) : scr_h_ff;
      cfg.pitch = pitch_ff;
      cfg.db_on = db_on_ff;
      if (depth_ff == DEPTH_24) begin
         cfg.bpp = BPP_DEPTH_24;
      end else if (depth_ff == DEPTH_16) begin
         cfg.bpp = BPP_DEPTH_16;
      end else begin
         cfg.bpp = BPP_OTHER;
      end
   end

endmodule

// ===== hdl/rcd_clip.sv =====
// ---------------------------------------------------------------------------
// rcd_clip
// Input register and rectangle clip / move check.
// ---------------------------------------------------------------------------
`include "rect_copy_descriptor_gen_assert.svh"

module rcd_clip (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_take,
   input  rcd_pkg::req_type   req,
   input  rcd_pkg::cfg_type   cfg,
   output logic               geom_valid,
   output rcd_pkg::geom_type  geom
);
   import rcd_pkg::*;

   req_type     req_ff;
   logic        req_vld_ff;
   geom_type    geom_in;

   logic signed [17:0] sx, sy, sw, sh, dx, dy, dw, dh, scw, sch;
   logic signed [17:0] x1, y1, cx0, cy0, cx1, cy1;
   logic               pres_out, pres_empty, mv_bad, mv_up;
   logic [13:0]        first_row;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_take;
      end
      if (req_take) begin
         req_ff <= req;
      end
   end

   // widen everything to one signed domain
   always_comb begin
      sx  = $signed({{2{req_ff.src_x[15]}}, req_ff.src_x});
      sy  = $signed({{2{req_ff.src_y[15]}}, req_ff.src_y});
      dx  = $signed({{2{req_ff.dst_x[15]}}, req_ff.dst_x});
      dy  = $signed({{2{req_ff.dst_y[15]}}, req_ff.dst_y});
      sw  = $signed({3'b000, req_ff.src_width});
      sh  = $signed({3'b000, req_ff.src_height});
      dw  = $signed({3'b000, req_ff.dst_width});
      dh  = $signed({3'b000, req_ff.dst_height});
      scw = $signed({4'b0000, cfg.scr_w});
      sch = $signed({4'b0000, cfg.scr_h});
   end

   // present: clip to the screen
   always_comb begin
      x1  = sx + sw;
      y1  = sy + sh;
      pres_out = (x1 <= 18'sd0) || (y1 <= 18'sd0) || (sx >= scw) || (sy >= sch);
      cx0 = (sx < 18'sd0) ? 18'sd0 : sx;
      cy0 = (sy < 18'sd0) ? 18'sd0 : sy;
      cx1 = (x1 > scw) ? scw : x1;
      cy1 = (y1 > sch) ? sch : y1;
      pres_empty = (cx1 <= cx0) || (cy1 <= cy0);
   end

   // move: reject checks and row order
   always_comb begin
      mv_bad = (sw == 18'sd0) || (sh == 18'sd0) || (dw != sw) || (dh != sh) ||
               (sx < 18'sd0) || (sy < 18'sd0) || (dx < 18'sd0) || (dy < 18'sd0) ||
               (sx + sw > scw) || (y1 > sch) || (dx + dw > scw) || (dy + dh > sch);
      mv_up     = (dy > sy) && (dy < y1);
      first_row = mv_up ? (req_ff.src_height[13:0] - 14'd1) : 14'd0;
   end

   // descriptor geometry; all fields but status zero unless copying
   always_comb begin
      geom_in = '0;
      if (req_ff.command == CMD_PRESENT) begin
         if (!cfg.db_on || pres_out || pres_empty) begin
            geom_in.status = STATUS_EMPTY;
         end else begin
            geom_in.status   = STATUS_COPY;
            geom_in.src_row  = cy0[13:0];
            geom_in.src_col  = cx0[13:0];
            geom_in.dst_row  = cy0[13:0];
            geom_in.dst_col  = cx0[13:0];
            geom_in.width_px = 14'(cx1 - cx0);
            geom_in.rows     = 14'(cy1 - cy0);
            geom_in.bpp      = cfg.bpp;
         end
      end else begin
         if (!cfg.db_on || mv_bad) begin
            geom_in.status = STATUS_REJECT;
         end else begin
            geom_in.status    = STATUS_COPY;
            geom_in.src_row   = sy[13:0] + first_row;
            geom_in.src_col   = sx[13:0];
            geom_in.dst_row   = dy[13:0] + first_row;
            geom_in.dst_col   = dx[13:0];
            geom_in.width_px  = sw[13:0];
            geom_in.rows      = sh[13:0];
            geom_in.bottom_up = mv_up;
            geom_in.bpp       = cfg.bpp;
         end
      end
   end

   assign geom_valid = req_vld_ff;
   assign geom       = geom_in;

   // bottom-up order only for an accepted move
   `RCD_ASSERT_IMP(a_up_is_move, clock, reset,
      req_vld_ff && (req_ff.command == CMD_PRESENT), geom_in.bottom_up == 1'b0)

endmodule

// ===== hdl/rcd_offset.sv =====
// ---------------------------------------------------------------------------
// rcd_offset
// Byte offset and row size products, result register and strobe.
// ---------------------------------------------------------------------------
`include "rect_copy_descriptor_gen_assert.svh"

module rcd_offset #(
   parameter int OFFSET_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               geom_valid,
   input  rcd_pkg::geom_type  geom,
   input  logic [15:0]        pitch,
   output logic               rsp_strobe,
   output rcd_pkg::rsp_type   rsp
);
   import rcd_pkg::*;

   localparam int          OFF_KEEP = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
   localparam logic [31:0] OFF_MASK = 32'((64'd1 << OFF_KEEP) - 64'd1);

   rsp_type     rsp_ff, rsp_in;
   logic        strobe_ff;
   logic [30:0] src_off, dst_off;
   logic [16:0] bytes;

   // row * pitch + column * bytes per pixel
   always_comb begin
      src_off = 31'(geom.src_row * pitch) + 31'(geom.src_col * geom.bpp);
      dst_off = 31'(geom.dst_row * pitch) + 31'(geom.dst_col * geom.bpp);
      bytes   = 17'(geom.width_px * geom.bpp);

      rsp_in.status           = geom.status;
      rsp_in.first_src_offset = {1'b0, src_off} & OFF_MASK;
      rsp_in.first_dst_offset = {1'b0, dst_off} & OFF_MASK;
      rsp_in.row_bytes        = bytes[15:0];
      rsp_in.row_count        = geom.rows;
      rsp_in.bottom_up        = geom.bottom_up;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= geom_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   // a non-copy result carries no descriptor
   `RCD_ASSERT_IMP(a_idle_fields_zero, clock, reset,
      rsp_strobe && (rsp.status != STATUS_COPY),
      (rsp.row_count == 14'd0) && (rsp.row_bytes == 16'd0) && !rsp.bottom_up)
   // a copy always moves at least one row
   `RCD_ASSERT_IMP(a_copy_has_rows, clock, reset,
      rsp_strobe && (rsp.status == STATUS_COPY), rsp.row_count != 14'd0)

endmodule

// ===== hdl/rect_copy_descriptor_gen.sv =====
// ---------------------------------------------------------------------------
// rect_copy_descriptor_gen
// Clips or checks a blit rectangle and emits a row mover descriptor.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start / busy           req  (rcd_pkg::req_type)
//  result    rsp_strobe (1 cycle)   rsp  (rcd_pkg::rsp_type)
//  config    csr_valid / csr_ready  csr_index, csr_wdata
//
// One request per cycle while busy is low; each result passes through the input
// register and the result register.
// Synchronous reset clears the pipeline valids and the configuration registers;
// busy is held high and csr_ready low while reset is high.
// The result side has no back-pressure, so nothing in the pipeline ever stalls.
// ---------------------------------------------------------------------------
`include "rect_copy_descriptor_gen_assert.svh"

module rect_copy_descriptor_gen #(
   parameter int MAX_DIM     = 8192,
   parameter int OFFSET_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  rcd_pkg::req_type                req,
   output logic                            rsp_strobe,
   output rcd_pkg::rsp_type                rsp,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rcd_pkg::*;

   cfg_type  cfg;
   geom_type geom;
   logic     geom_valid;
   logic     req_take;

   assign busy     = reset;
   assign req_take = start && !busy;

   rcd_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcd_clip u_clip (
      .clock      (clock),
      .reset      (reset),
      .req_take   (req_take),
      .req        (req),
      .cfg        (cfg),
      .geom_valid (geom_valid),
      .geom       (geom)
   );

   rcd_offset #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_offset (
      .clock      (clock),
      .reset      (reset),
      .geom_valid (geom_valid),
      .geom       (geom),
      .pitch      (cfg.pitch),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   // every result traces back to a request taken ahead of the input and result registers
   `RCD_ASSERT_IMP(a_rsp_has_req, clock, reset,
      rsp_strobe, $past(req_take, 2))

endmodule
